/* rtl/vfsf_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// vfsf_pkg: shared types and constants
// Float masks and flag bit positions for the three-lane subtract.
// ---------------------------------------------------------------------------
package vfsf_pkg;
	localparam logic [31:0] EXP_MASK   = 32'h7f800000;
	localparam logic [31:0] SIGN_MASK  = 32'h80000000;
	localparam logic [30:0] MAX_FINITE = 31'h7f7fffff;
	localparam int FLAG_Z = 0;
	localparam int FLAG_S = 1;
	localparam int FLAG_U = 2;
	localparam int FLAG_O = 3;

	// per-lane result after the first stage
	typedef struct packed {
		logic        done;   // result fixed early (zero, flush)
		logic [31:0] res;
		logic [3:0]  fl;
		logic        sign;
		logic [7:0]  ex;
		logic [49:0] r;      // 2.48 magnitude with sticky lsb
	} lane_mid_t;

	typedef struct packed {
		logic [31:0] res;
		logic [3:0]  fl;
	} lane_out_t;
endpackage
`default_nettype wire

/* rtl/vector_float_subtract_flags_top.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// vector_float_subtract_flags_top: three-lane float subtract with flags
// Lanes x, y, z subtract in parallel; a merge stage forms MAC/status words.
// ---------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | valid/stall, left_*, right_*, clear_sticky | into block
//  out     | out_valid/out_stall, diff_*, flags          | out of block
//
// Registered stages: align, normalize, merge register; one transaction per
// cycle while not stalled, set by the lane pipelines. Pipeline advances as
// one unit: a stall on the output freezes every stage and raises in_stall
// only while a valid result is held. Reset clears valid and sticky bits.
module vector_float_subtract_flags_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] left_x,
	input  wire logic [31:0] left_y,
	input  wire logic [31:0] left_z,
	input  wire logic [31:0] right_x,
	input  wire logic [31:0] right_y,
	input  wire logic [31:0] right_z,
	input  wire logic        clear_sticky,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] diff_x,
	output logic      [31:0] diff_y,
	output logic      [31:0] diff_z,
	output logic      [15:0] mac_flags,
	output logic      [9:0]  status_flags,
	output logic             in_bounds
);
	logic v_s1, v_s2, clr_s1, clr_s2, adv;
	vfsf_pkg::lane_out_t lx, ly, lz;
	logic [15:0] mac;
	logic [9:0] st;
	logic ib;

	// whole pipe moves unless a held result is blocked
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	vfsf_lane u_x (.clk(clk), .en(adv), .a_raw(left_x), .b_raw(right_x), .out_s2(lx));
	vfsf_lane u_y (.clk(clk), .en(adv), .a_raw(left_y), .b_raw(right_y), .out_s2(ly));
	vfsf_lane u_z (.clk(clk), .en(adv), .a_raw(left_z), .b_raw(right_z), .out_s2(lz));

	// sticky updates only for real transactions reaching the merge
	vfsf_merge u_merge (
		.clk(clk), .arst_n(arst_n), .en(adv && v_s2), .clear(clr_s2),
		.fl_x(lx.fl), .fl_y(ly.fl), .fl_z(lz.fl),
		.mac(mac), .status(st), .in_bnd(ib)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			clr_s1 <= clear_sticky;
			clr_s2 <= clr_s1;
			diff_x <= lx.res;
			diff_y <= ly.res;
			diff_z <= lz.res;
			mac_flags <= mac;
			status_flags <= st;
			in_bounds <= ib;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status_flags))
		else $error("held result changed");
	a_inb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_bounds == !status_flags[7])
		else $error("in_bounds mismatch");
	a_mac_w: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mac_flags[0] || mac_flags[4] || mac_flags[8] || mac_flags[12]) == 1'b0)
		else $error("w lane flag set");
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status_flags[3:0] & ~status_flags[9:6]) == 4'd0)
		else $error("sticky lost current flag");
endmodule
`default_nettype wire

/* rtl/vfsf_lane.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// vfsf_lane: one subtract lane, two stages
// Stage 1 aligns and adds; stage 2 normalizes, truncates and flags.
// ---------------------------------------------------------------------------
module vfsf_lane (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic [31:0]         a_raw,
	input  wire logic [31:0]         b_raw,
	output vfsf_pkg::lane_out_t      out_s2
);
	function automatic logic [31:0] clean(input logic [31:0] x);
		if ((x & vfsf_pkg::EXP_MASK) == 32'd0) return x & vfsf_pkg::SIGN_MASK;
		if ((x & vfsf_pkg::EXP_MASK) == vfsf_pkg::EXP_MASK)
			return {x[31], vfsf_pkg::MAX_FINITE};
		return x;
	endfunction

	logic [31:0] a, b;
	logic sa, sb, sx, sy;
	logic [30:0] ma, mb, bx, by;
	logic [7:0] d;
	logic [49:0] mx, my, bt;
	logic lost;
	vfsf_pkg::lane_mid_t mid, mid_s1;

	always_comb begin
		a = clean(a_raw);
		b = clean(b_raw);
		sa = a[31];
		sb = ~b[31];
		ma = a[30:0];
		mb = b[30:0];
		if (ma >= mb) begin
			sx = sa; bx = ma; sy = sb; by = mb;
		end else begin
			sx = sb; bx = mb; sy = sa; by = ma;
		end
		d = bx[30:23] - by[30:23];
		mx = {1'b0, 1'b1, bx[22:0], 25'd0};
		my = {1'b0, 1'b1, by[22:0], 25'd0};
		bt = '0;
		lost = 1'b0;
		if (by != 31'd0) begin
			if (d >= 8'd49) begin
				lost = 1'b1;
			end else begin
				bt = my >> d;
				lost = (my & ((50'd1 << d) - 50'd1)) != 50'd0;
			end
		end
		mid = '0;
		mid.sign = sx;
		mid.ex = bx[30:23];
		if (ma == 31'd0 && mb == 31'd0) begin
			mid.done = 1'b1;
			mid.res = {sa & sb, 31'd0};
			mid.fl[vfsf_pkg::FLAG_Z] = 1'b1;
			mid.fl[vfsf_pkg::FLAG_S] = sa & sb;
		end else if (sx != sy && bx == by) begin
			mid.done = 1'b1;
			mid.fl[vfsf_pkg::FLAG_Z] = 1'b1;
		end else if (sx == sy) begin
			// lost bits fold into the sticky lsb
			mid.r = mx + bt;
			mid.r[0] = mid.r[0] | lost;
		end else begin
			// borrow for lost bits; sticky lsb stays set in that case
			mid.r = mx - bt - {49'd0, lost};
			mid.r[0] = mid.r[0] | lost;
		end
	end

	always_ff @(posedge clk) begin
		if (en) mid_s1 <= mid;
	end

	logic [5:0] p;
	logic [9:0] e;
	logic [49:0] nrm;
	logic rem;
	vfsf_pkg::lane_out_t o;

	always_comb begin
		p = '0;
		for (int i = 0; i < 50; i++) begin
			if (mid_s1.r[i]) p = 6'(i);
		end
		nrm = mid_s1.r << (6'd49 - p);
		// value = r * 2^(ex-150-25); exponent e = p + ex - 48
		e = 10'(p) + 10'(mid_s1.ex) - 10'd48;
		rem = nrm[25:0] != 26'd0;
		o.res = {mid_s1.sign, 31'd0};
		o.fl = '0;
		o.fl[vfsf_pkg::FLAG_S] = mid_s1.sign;
		if (mid_s1.done) begin
			o.res = mid_s1.res;
			o.fl = mid_s1.fl;
		end else if (mid_s1.r == 50'd0 || e[9] || e == 10'd0) begin
			o.fl[vfsf_pkg::FLAG_Z] = 1'b1;
			o.fl[vfsf_pkg::FLAG_U] = 1'b1;
		end else if (e > 10'd254 ||
		             (e == 10'd254 && nrm[48:26] == 23'h7fffff && rem)) begin
			o.res = {mid_s1.sign, vfsf_pkg::MAX_FINITE};
			o.fl[vfsf_pkg::FLAG_O] = 1'b1;
		end else begin
			o.res = {mid_s1.sign, e[7:0], nrm[48:26]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) out_s2 <= o;
	end
endmodule
`default_nettype wire

/* rtl/vfsf_merge.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// vfsf_merge: flag merge and sticky status
// Builds MAC and status words from three lane flag sets.
// ---------------------------------------------------------------------------
module vfsf_merge (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        clear,
	input  wire logic [3:0]  fl_x,
	input  wire logic [3:0]  fl_y,
	input  wire logic [3:0]  fl_z,
	output logic      [15:0] mac,
	output logic      [9:0]  status,
	output logic             in_bnd
);
	logic [3:0] sticky_q, cur, nxt;

	always_comb begin
		cur = fl_x | fl_y | fl_z;
		nxt = (clear ? 4'd0 : sticky_q) | cur;
		for (int f = 0; f < 4; f++) begin
			mac[f*4 +: 4] = {fl_x[f], fl_y[f], fl_z[f], 1'b0};
		end
		status = {nxt, 2'b00, cur};
		in_bnd = ~nxt[vfsf_pkg::FLAG_S];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sticky_q <= '0;
		else if (en) sticky_q <= nxt;
	end
endmodule
`default_nettype wire
